/* rtl/marching_squares_triangulator_defines.svh */
// ----------------------------------------------------------------------------
// Marching squares triangulator: assertion macros
// Shorthand for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef MARCHING_SQUARES_TRIANGULATOR_DEFINES_SVH
`define MARCHING_SQUARES_TRIANGULATOR_DEFINES_SVH

// General check, switched off while reset is asserted.
`define MSQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Hold check: a signal stays put while its channel stalls.
`define MSQ_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    ((vld) && !(rdy) |=> $stable(sig))) else $error(msg);

`endif

/* rtl/msq_pkg.sv */
// ----------------------------------------------------------------------------
// Marching squares triangulator: shared package
// Widths, register indexes, the triangle table and the cell record.
// ----------------------------------------------------------------------------
`default_nettype none

package msq_pkg;

  localparam int CoordW    = 25;
  localparam int GridW     = 16;
  localparam int CornerW   = 16;
  localparam int CaseW     = 4;
  localparam int CellSizeW = 9;
  localparam int ThreshW   = 16;
  localparam int CfgDataW  = 16;
  localparam int CfgIdxW   = 1;
  localparam int MaxTris   = 5;
  localparam int TriIdxW   = 3;
  localparam int CodeW     = 3;
  localparam int QueueDepth = 2;

  localparam logic [CellSizeW-1:0] CellSizeRst  = 9'd16;
  localparam logic [ThreshW-1:0]   ThresholdRst = 16'd32768;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegCellSize  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegThreshold = 1'b1;

  // offset selectors for a vertex coordinate
  localparam logic [1:0] OffNone = 2'd0;
  localparam logic [1:0] OffHalf = 2'd1;
  localparam logic [1:0] OffFull = 2'd2;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic [CellSizeW-1:0] cell_size;
    logic [ThreshW-1:0]   threshold;
  } cfg_t;

  typedef struct packed {
    coord_t           ox;
    coord_t           oy;
    logic [CaseW-1:0] cell_case;
  } cell_t;

  typedef struct packed {
    coord_t           ax;
    coord_t           ay;
    coord_t           bx;
    coord_t           by_coord;
    coord_t           cx;
    coord_t           cy;
    logic [CaseW-1:0] case_index;
    logic             last_triangle;
  } tri_t;

  // vertex codes: corners tl, tr, br, bl, then midpoints top, right, bottom, left
  localparam logic [CodeW-1:0] TriTable [16][MaxTris][3] = '{
    '{'{0,0,0}, '{0,0,0}, '{0,0,0}, '{0,0,0}, '{0,0,0}},
    '{'{7,3,6}, '{0,0,0}, '{0,0,0}, '{0,0,0}, '{0,0,0}},
    '{'{6,2,5}, '{0,0,0}, '{0,0,0}, '{0,0,0}, '{0,0,0}},
    '{'{7,3,2}, '{7,5,2}, '{0,0,0}, '{0,0,0}, '{0,0,0}},
    '{'{4,1,5}, '{0,0,0}, '{0,0,0}, '{0,0,0}, '{0,0,0}},
    '{'{7,3,6}, '{4,1,5}, '{7,4,6}, '{5,4,6}, '{0,0,0}},
    '{'{4,1,2}, '{4,6,2}, '{0,0,0}, '{0,0,0}, '{0,0,0}},
    '{'{7,3,6}, '{4,1,5}, '{6,2,5}, '{7,4,6}, '{5,4,6}},
    '{'{7,0,4}, '{0,0,0}, '{0,0,0}, '{0,0,0}, '{0,0,0}},
    '{'{4,0,3}, '{4,6,3}, '{0,0,0}, '{0,0,0}, '{0,0,0}},
    '{'{6,2,5}, '{7,0,4}, '{7,4,6}, '{5,4,6}, '{0,0,0}},
    '{'{7,3,6}, '{6,2,5}, '{7,0,4}, '{7,4,6}, '{5,4,6}},
    '{'{7,0,1}, '{7,5,1}, '{0,0,0}, '{0,0,0}, '{0,0,0}},
    '{'{7,3,6}, '{7,0,4}, '{4,1,5}, '{7,4,6}, '{5,4,6}},
    '{'{6,2,5}, '{7,0,4}, '{4,1,5}, '{7,4,6}, '{5,4,6}},
    '{'{0,1,2}, '{0,3,2}, '{0,0,0}, '{0,0,0}, '{0,0,0}}
  };

  localparam logic [TriIdxW-1:0] TriCount [16] = '{
    0, 1, 1, 2, 1, 4, 2, 5, 1, 2, 4, 5, 2, 5, 5, 2
  };

  localparam logic [1:0] OffX [8] = '{OffNone, OffFull, OffFull, OffNone,
                                      OffHalf, OffFull, OffHalf, OffNone};
  localparam logic [1:0] OffY [8] = '{OffNone, OffNone, OffFull, OffFull,
                                      OffNone, OffHalf, OffFull, OffHalf};

endpackage

`default_nettype wire

/* rtl/msq_front.sv */
// ----------------------------------------------------------------------------
// Marching squares triangulator: front stage
// Accepts cells, classifies the corners and scales the cell origin.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire msq_pkg::cfg_t                cfg_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [msq_pkg::GridW-1:0]    cell_x_i,
  input  wire logic [msq_pkg::GridW-1:0]    cell_y_i,
  input  wire logic [msq_pkg::CornerW-1:0]  corner_tl_i,
  input  wire logic [msq_pkg::CornerW-1:0]  corner_tr_i,
  input  wire logic [msq_pkg::CornerW-1:0]  corner_br_i,
  input  wire logic [msq_pkg::CornerW-1:0]  corner_bl_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output msq_pkg::cell_t                    out_cell_o
);
  import msq_pkg::*;

  localparam int ProdW = CoordW + 1;

  logic                      valid_q, valid_d;
  cell_t                     cell_q;
  logic signed [ProdW-1:0]   prod_x, prod_y;
  logic [CaseW-1:0]          cell_case;
  logic                      take;

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  assign prod_x = ProdW'($signed(cell_x_i)) * ProdW'($signed({1'b0, cfg_i.cell_size}));
  assign prod_y = ProdW'($signed(cell_y_i)) * ProdW'($signed({1'b0, cfg_i.cell_size}));

  assign cell_case = {corner_tl_i > cfg_i.threshold, corner_tr_i > cfg_i.threshold,
                      corner_br_i > cfg_i.threshold, corner_bl_i > cfg_i.threshold};

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cell_q.ox        <= prod_x[CoordW-1:0];
      cell_q.oy        <= prod_y[CoordW-1:0];
      cell_q.cell_case <= cell_case;
    end
  end

  assign out_valid_o = valid_q;
  assign out_cell_o  = cell_q;

endmodule

`default_nettype wire

/* rtl/msq_queue.sv */
// ----------------------------------------------------------------------------
// Marching squares triangulator: cell queue
// Short first-in first-out buffer between the front and back stages.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_queue #(
  parameter int Depth = msq_pkg::QueueDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire msq_pkg::cell_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output msq_pkg::cell_t      head_o
);
  import msq_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cell_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/msq_back.sv */
// ----------------------------------------------------------------------------
// Marching squares triangulator: back stage
// Walks the head cell's triangle list, one triangle per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire msq_pkg::cfg_t  cfg_i,
  input  wire logic           empty_i,
  input  wire msq_pkg::cell_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output msq_pkg::tri_t       out_tri_o
);
  import msq_pkg::*;

  logic               valid_q, valid_d;
  tri_t               tri_q, tri_d;
  logic [TriIdxW-1:0] k_q, k_d;
  logic [TriIdxW-1:0] n_tris;
  logic               step, emit, last;
  coord_t             size_c, half_c;
  coord_t             vx [3];
  coord_t             vy [3];

  function automatic coord_t offset(input logic [1:0] sel, input coord_t s,
                                    input coord_t h);
    coord_t r;
    case (sel)
      OffHalf: r = h;
      OffFull: r = s;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign size_c = coord_t'({1'b0, cfg_i.cell_size});
  assign half_c = coord_t'({1'b0, cfg_i.cell_size[CellSizeW-1:1]});

  assign n_tris = TriCount[head_i.cell_case];
  assign last   = (k_q == n_tris - 1'b1);
  assign step   = !empty_i && (!valid_q || out_ready_i);
  assign emit   = step && (n_tris != '0);
  // an empty case leaves the queue with no triangle
  assign pop_o  = step && ((n_tris == '0) || last);

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      vx[v] = head_i.ox + offset(OffX[TriTable[head_i.cell_case][k_q][v]], size_c, half_c);
      vy[v] = head_i.oy + offset(OffY[TriTable[head_i.cell_case][k_q][v]], size_c, half_c);
    end
    tri_d.ax            = vx[0];
    tri_d.ay            = vy[0];
    tri_d.bx            = vx[1];
    tri_d.by_coord      = vy[1];
    tri_d.cx            = vx[2];
    tri_d.cy            = vy[2];
    tri_d.case_index    = head_i.cell_case;
    tri_d.last_triangle = last;
  end

  always_comb begin
    valid_d = valid_q;
    k_d     = k_q;
    if (emit) begin
      valid_d = 1'b1;
      k_d     = last ? '0 : k_q + 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      k_q     <= '0;
    end else begin
      valid_q <= valid_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      tri_q <= tri_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_tri_o   = tri_q;

endmodule

`default_nettype wire

/* rtl/marching_squares_triangulator.sv */
// ----------------------------------------------------------------------------
// Marching squares triangulator: top level
// Turns grid cells into the triangles of their marching squares case.
// ----------------------------------------------------------------------------
// One cell in, zero to five triangles out. The front stage takes a cell every
// cycle while the cell queue has room, compares the corners with the threshold
// and scales the origin by the cell size; the back stage then emits one
// triangle of the head cell per cycle while the result channel is not
// stalled, and pops an empty cell without a triangle. The first triangle of
// a cell passes the front register, the cell queue and the output register.
// Register writes are only to be made while no cell is in flight.
`default_nettype none

module marching_squares_triangulator #(
  parameter int FifoDepth = msq_pkg::QueueDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [msq_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [msq_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // cell_x, cell_y, corner_tl, corner_tr, corner_br, corner_bl
  input  wire logic [95:0]                   s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // ax, ay, bx, by_coord, cx, cy, two zero bits
  output logic [151:0]                       m_axis_tdata,
  // case_index
  output logic [msq_pkg::CaseW-1:0]          m_axis_tuser,
  output logic                               m_axis_tlast
);
  import msq_pkg::*;

  logic [CellSizeW-1:0] cell_size_q;
  logic [ThreshW-1:0]   threshold_q;
  cfg_t                 cfg;
  logic                 f_valid, q_full, q_empty, q_pop;
  cell_t                f_cell, q_head;
  tri_t                 out_tri;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= CellSizeRst;
      threshold_q <= ThresholdRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegCellSize:  cell_size_q <= cfg_wdata_i[CellSizeW-1:0];
        RegThreshold: threshold_q <= cfg_wdata_i[ThreshW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.cell_size = cell_size_q;
  assign cfg.threshold = threshold_q;

  msq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cell_x_i    (s_axis_tdata[15:0]),
    .cell_y_i    (s_axis_tdata[31:16]),
    .corner_tl_i (s_axis_tdata[47:32]),
    .corner_tr_i (s_axis_tdata[63:48]),
    .corner_br_i (s_axis_tdata[79:64]),
    .corner_bl_i (s_axis_tdata[95:80]),
    .out_valid_o (f_valid),
    .out_ready_i (!q_full),
    .out_cell_o  (f_cell)
  );

  msq_queue #(
    .Depth (FifoDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_cell),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  msq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .empty_i     (q_empty),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_tri_o   (out_tri)
  );

  assign m_axis_tdata = {2'b00, out_tri.cy, out_tri.cx, out_tri.by_coord,
                         out_tri.bx, out_tri.ay, out_tri.ax};
  assign m_axis_tuser = out_tri.case_index;
  assign m_axis_tlast = out_tri.last_triangle;

endmodule

`default_nettype wire

/* rtl/msq_checker.sv */
// ----------------------------------------------------------------------------
// Marching squares triangulator: port checker
// Watches the result channel and the grouping of triangles into cells.
// ----------------------------------------------------------------------------
`default_nettype none

`include "marching_squares_triangulator_defines.svh"

module msq_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic [151:0]                  m_axis_tdata,
  input  wire logic [msq_pkg::CaseW-1:0]     m_axis_tuser,
  input  wire logic                          m_axis_tlast
);
  import msq_pkg::*;

  logic               xfer;
  logic               mid_q;
  logic [CaseW-1:0]   case_q;
  logic [TriIdxW-1:0] cnt_q;

  assign xfer = m_axis_tvalid && m_axis_tready;

  // track the cell whose triangles are being transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q  <= 1'b0;
      case_q <= '0;
      cnt_q  <= '0;
    end else if (xfer) begin
      mid_q  <= !m_axis_tlast;
      case_q <= m_axis_tuser;
      cnt_q  <= m_axis_tlast ? '0 : cnt_q + 1'b1;
    end
  end

  `MSQ_ASSERT_HOLD(a_tdata_hold, clk_i, rst_ni, m_axis_tvalid, m_axis_tready, m_axis_tdata, "result payload changed while stalled")
  `MSQ_ASSERT(a_no_empty_case, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tuser != '0), "triangle emitted for an empty cell")
  `MSQ_ASSERT(a_case_within_cell, clk_i, rst_ni, (m_axis_tvalid && mid_q) |-> (m_axis_tuser == case_q), "case changed inside one cell")
  `MSQ_ASSERT(a_max_tris, clk_i, rst_ni, m_axis_tvalid |-> (cnt_q < TriIdxW'(MaxTris)), "more triangles in one cell than the table allows")

endmodule

bind marching_squares_triangulator msq_checker u_msq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
